// ===== sv/sacld_pkg.sv =====
// ----------------------------------------------------------------------------
// sacld_pkg
// Shared types and constants of the set-associative cache LRU directory:
// configuration register indexes, field widths, the controller states and
// the lookup status that travels from the way logic to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sacld_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_WAYS       = 2'd0;
	localparam logic [1:0] REG_SET_BITS   = 2'd1;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd2;
	localparam logic [1:0] REG_WB_MODE    = 2'd3;

	// Fixed field widths.
	localparam int CFG_W    = 5;
	localparam int WAY_OUT_W = 4;
	localparam int SET_OUT_W = 6;
	localparam int OFS_W    = 5;
	localparam int RANK_W   = 4;
	localparam int VTAG_W   = 32;

	// Largest legal block_bits and set_bits values.
	localparam logic [2:0] BLOCK_BITS_MAX = 3'd5;
	localparam logic [2:0] SET_BITS_MAX   = 3'd6;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} sacld_state_t;

	// Lookup status of one request.
	typedef struct packed {
		logic                 hit;
		logic                 evict;
		logic [WAY_OUT_W-1:0] way;
	} sacld_lkp_t;

endpackage

`default_nettype wire

// ===== sv/set_assoc_cache_lru_directory.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_directory
// Tag directory of a set-associative cache with true-LRU replacement and a
// write-back or write-through memory policy.
// ----------------------------------------------------------------------------
// Usage:
// A request (req_type, address) is a transfer on the in_valid/in_ready
// channel. One result per request leaves on the out_valid/out_ready channel:
// hit or miss, the way hit or the LRU victim, set index, byte offset, and
// the fill, write-back and write-through flags.
// Each request first reads the set's row from the tag memory and the
// metadata memory at its transfer, then compares, chooses the victim and
// writes the modified row back. A new request is taken only once the lookup
// of the previous one has finished; the result is then registered.
// The result sits in an output register, so the next request is accepted
// while an earlier result waits. If the receiver stalls with the output
// register still full when the next lookup finishes, the lookup holds its
// read data and waits until the register drains.
// Reset (arst_n low) loads the register defaults and marks every set row as
// cleared (no valid, no dirty lines, rank equal to way number); no clearing
// pass is needed. A configuration write clears the rows alike; the user must
// write only while idle, unenforced. Tags are stored only when installed.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_directory
	import sacld_pkg::*;
#(
	parameter int MAX_WAYS  = 16,
	parameter int MAX_SETS  = 64,
	parameter int ADDR_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration write port
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	// Request channel
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              req_type,
	input  wire logic [31:0]       address,
	// Result channel
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   hit,
	output logic [WAY_OUT_W-1:0]   way,
	output logic [SET_OUT_W-1:0]   set_index,
	output logic [OFS_W-1:0]       byte_offset,
	output logic                   bypass,
	output logic                   fill_block,
	output logic                   evict_dirty,
	output logic [VTAG_W-1:0]      victim_tag,
	output logic                   mem_write
);

	localparam int IDX_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int META_W = MAX_WAYS * (2 + RANK_W);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] ways_q;
	logic [2:0]       set_bits_q;
	logic [2:0]       block_bits_q;
	logic             wb_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q       <= CFG_W'(1);
			set_bits_q   <= 3'd0;
			block_bits_q <= 3'd2;
			wb_mode_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WAYS:       ways_q       <= cfg_wdata;
				REG_SET_BITS:   set_bits_q   <= cfg_wdata[2:0];
				REG_BLOCK_BITS: block_bits_q <= cfg_wdata[2:0];
				REG_WB_MODE:    wb_mode_q    <= cfg_wdata[0];
				default:        ;
			endcase
		end
	end

	// Clamped configuration values.
	logic [CFG_W-1:0] ways_c;
	logic [2:0]       sb_c;
	logic [2:0]       bb_c;

	assign ways_c = (ways_q > CFG_W'(MAX_WAYS)) ? CFG_W'(MAX_WAYS) : ways_q;
	assign sb_c   = (set_bits_q > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_q;
	assign bb_c   = (block_bits_q > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : block_bits_q;

	// ------------------------------------------------------------------
	// Address split
	// ------------------------------------------------------------------
	logic [ADDR_BITS-1:0] addr_m;
	logic [OFS_W-1:0]     offset_d;
	logic [SET_OUT_W-1:0] set_raw;
	logic [IDX_W-1:0]     set_d;
	logic [ADDR_BITS-1:0] tag_d;
	logic [IDX_W-1:0]     set_mod [64];

	// Set index reduction modulo the number of sets, as a constant table.
	for (genvar g = 0; g < 64; g++) begin : g_set_mod
		assign set_mod[g] = IDX_W'(g % MAX_SETS);
	end

	always_comb begin
		addr_m   = address[ADDR_BITS-1:0];
		offset_d = addr_m[OFS_W-1:0] & OFS_W'((6'd1 << bb_c) - 6'd1);
		set_raw  = SET_OUT_W'(addr_m >> bb_c) & SET_OUT_W'((7'd1 << sb_c) - 7'd1);
		set_d    = set_mod[set_raw];
		tag_d    = addr_m >> ({1'b0, bb_c} + {1'b0, sb_c});
	end

	// ------------------------------------------------------------------
	// Controller
	// ------------------------------------------------------------------
	sacld_state_t state_q;
	sacld_state_t state_d;
	logic         accept;
	logic         finish;
	logic         out_free;

	assign out_free = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Request registers of the lookup stage
	// ------------------------------------------------------------------
	logic                 write_s1;
	logic [IDX_W-1:0]     set_s1;
	logic [OFS_W-1:0]     offset_s1;
	logic [ADDR_BITS-1:0] tag_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			write_s1  <= req_type;
			set_s1    <= set_d;
			offset_s1 <= offset_d;
			tag_s1    <= tag_d;
		end
	end

	// ------------------------------------------------------------------
	// Tag memory and metadata memory, one row per set
	// ------------------------------------------------------------------
	logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem [MAX_SETS];
	logic [META_W-1:0]                  meta_mem [MAX_SETS];
	logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_row_s1;
	logic [META_W-1:0]                  meta_row_s1;
	logic [MAX_SETS-1:0]                row_vld_q;
	logic                               row_vld_s1;
	logic                               mem_we;
	logic [META_W-1:0]                  meta_wr;
	sacld_lkp_t                         lkp;

	// Read the set's row at request transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_row_s1  <= tag_mem[set_d];
			meta_row_s1 <= meta_mem[set_d];
		end
	end

	// Write back the modified row at the end of the lookup.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			meta_mem[set_s1] <= meta_wr;
			if (!lkp.hit) begin
				tag_mem[set_s1][lkp.way[WAY_W-1:0]] <= tag_s1;
			end
		end
	end

	// Row valid flags: a cleared row reads as the reset contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			row_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				row_vld_q <= '0;
			end else if (mem_we) begin
				row_vld_q[set_s1] <= 1'b1;
			end
			if (accept) begin
				row_vld_s1 <= row_vld_q[set_d];
			end
		end
	end

	// ------------------------------------------------------------------
	// Way logic
	// ------------------------------------------------------------------
	logic [MAX_WAYS-1:0]              vld_row;
	logic [MAX_WAYS-1:0]              dty_row;
	logic [MAX_WAYS-1:0][RANK_W-1:0]  rank_row;
	logic [MAX_WAYS-1:0]              vld_new;
	logic [MAX_WAYS-1:0]              dty_new;
	logic [MAX_WAYS-1:0][RANK_W-1:0]  rank_new;
	logic [ADDR_BITS-1:0]             vtag;
	logic                             is_bypass;

	// Unpack the metadata row, or the reset row for a cleared set.
	always_comb begin
		if (row_vld_s1) begin
			{vld_row, dty_row, rank_row} = meta_row_s1;
		end else begin
			vld_row = '0;
			dty_row = '0;
			for (int i = 0; i < MAX_WAYS; i++) begin
				rank_row[i] = RANK_W'(i);
			end
		end
	end

	sacld_way_logic #(
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_way_logic (
		.ways     (ways_c),
		.is_write (write_s1),
		.wb_mode  (wb_mode_q),
		.tag      (tag_s1),
		.tag_row  (tag_row_s1),
		.vld_row  (vld_row),
		.dty_row  (dty_row),
		.rank_row (rank_row),
		.lkp      (lkp),
		.vtag     (vtag),
		.vld_new  (vld_new),
		.dty_new  (dty_new),
		.rank_new (rank_new)
	);

	assign is_bypass = (ways_c == '0);
	assign mem_we    = finish && !is_bypass;
	assign meta_wr   = {vld_new, dty_new, rank_new};

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			mem_write <= write_s1 && !wb_mode_q;
			bypass    <= is_bypass;
			if (is_bypass) begin
				hit         <= 1'b0;
				way         <= '0;
				set_index   <= '0;
				byte_offset <= '0;
				fill_block  <= 1'b0;
				evict_dirty <= 1'b0;
				victim_tag  <= '0;
			end else begin
				hit         <= lkp.hit;
				way         <= lkp.way;
				set_index   <= SET_OUT_W'(set_s1);
				byte_offset <= offset_s1;
				fill_block  <= !lkp.hit;
				evict_dirty <= lkp.evict;
				victim_tag  <= VTAG_W'(vtag);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/sacld_way_logic.sv =====
// ----------------------------------------------------------------------------
// sacld_way_logic
// Per-set way logic: tag match, LRU victim choice and the updated valid,
// dirty and rank row that is written back after the lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module sacld_way_logic
	import sacld_pkg::*;
#(
	parameter int MAX_WAYS  = 16,
	parameter int ADDR_BITS = 32
) (
	input  wire logic [CFG_W-1:0]                        ways,
	input  wire logic                                    is_write,
	input  wire logic                                    wb_mode,
	input  wire logic [ADDR_BITS-1:0]                    tag,
	input  wire logic [MAX_WAYS-1:0][ADDR_BITS-1:0]      tag_row,
	input  wire logic [MAX_WAYS-1:0]                     vld_row,
	input  wire logic [MAX_WAYS-1:0]                     dty_row,
	input  wire logic [MAX_WAYS-1:0][RANK_W-1:0]         rank_row,
	output sacld_lkp_t                                   lkp,
	output logic [ADDR_BITS-1:0]                         vtag,
	output logic [MAX_WAYS-1:0]                          vld_new,
	output logic [MAX_WAYS-1:0]                          dty_new,
	output logic [MAX_WAYS-1:0][RANK_W-1:0]              rank_new
);

	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	logic [MAX_WAYS-1:0] in_use;
	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] lru0;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    vic_way;
	logic [WAY_W-1:0]    sel_way;
	logic                hit;
	logic [RANK_W-1:0]   cur_rank;

	// Tag compare and rank-zero detect on every way in use.
	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			in_use[i] = CFG_W'(i) < ways;
			match[i]  = in_use[i] && vld_row[i] && (tag_row[i] == tag);
			lru0[i]   = in_use[i] && (rank_row[i] == '0);
		end
	end

	// Lowest numbered matching way and lowest numbered way of rank zero.
	always_comb begin
		hit_way = '0;
		vic_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_way = WAY_W'(i);
			end
			if (lru0[i]) begin
				vic_way = WAY_W'(i);
			end
		end
	end

	assign hit      = |match;
	assign sel_way  = hit ? hit_way : vic_way;
	assign cur_rank = rank_row[sel_way];

	// Lookup status and victim tag for the write-back address.
	always_comb begin
		lkp.hit   = hit;
		lkp.way   = WAY_OUT_W'(sel_way);
		lkp.evict = !hit && vld_row[sel_way] && dty_row[sel_way];
		vtag      = lkp.evict ? tag_row[sel_way] : '0;
	end

	// Updated row: install on a miss, update the dirty bit, promote the way.
	always_comb begin
		vld_new  = vld_row;
		dty_new  = dty_row;
		rank_new = rank_row;
		if (!hit) begin
			vld_new[sel_way] = 1'b1;
			dty_new[sel_way] = is_write && wb_mode;
		end else if (is_write) begin
			dty_new[sel_way] = wb_mode;
		end
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (in_use[i] && (rank_row[i] > cur_rank)) begin
				rank_new[i] = rank_row[i] - RANK_W'(1);
			end
		end
		rank_new[sel_way] = RANK_W'(ways - CFG_W'(1));
	end

endmodule

`default_nettype wire

// ===== sv/sacld_checker.sv =====
// ----------------------------------------------------------------------------
// sacld_checker
// Port-level checks of the cache directory: consistency of the result flags
// and holding of a stalled result. Bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sacld_checker
	import sacld_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic                 hit,
	input wire logic [WAY_OUT_W-1:0] way,
	input wire logic                 bypass,
	input wire logic                 fill_block,
	input wire logic                 evict_dirty,
	input wire logic [VTAG_W-1:0]    victim_tag
);

	// A bypassed access never hits, fills or evicts.
	a_bypass_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bypass |-> !hit && !fill_block && !evict_dirty)
		else $error("bypass result reports cache activity");

	// A cached access either hits or fills, never both.
	a_hit_xor_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bypass |-> hit != fill_block)
		else $error("hit and fill_block disagree");

	// A write-back only happens on a miss.
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evict_dirty |-> fill_block)
		else $error("eviction without a miss");

	// The victim tag is zero unless a write-back is reported.
	a_vtag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evict_dirty |-> victim_tag == '0)
		else $error("victim tag set without eviction");

	// A stalled result stays until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(way) && $stable(hit))
		else $error("stalled result changed");

endmodule

bind set_assoc_cache_lru_directory sacld_checker u_sacld_checker (.*);

`default_nettype wire
